// ----- src/imbt_pkg.sv -----
`default_nettype none

package imbt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int STATUS_W        = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ABSENT    = 2'd0,
        ST_MAC_MATCH = 2'd1,
        ST_MAC_DIFF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic write;
        logic preset;
        logic fail;
        logic scan_start;
        logic scan_step;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/imbt_if.sv -----
`default_nettype none

interface imbt_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [imbt_pkg::IP_W-1:0]  key_ip;
    logic [imbt_pkg::MAC_W-1:0] key_mac;

    modport source (output valid, output opcode, output key_ip, output key_mac, input ready);
    modport sink   (input valid, input opcode, input key_ip, input key_mac, output ready);
endinterface

interface imbt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [imbt_pkg::STATUS_W-1:0] lookup_status;
    logic                          insert_failed;

    modport source (output valid, output lookup_status, output insert_failed, input ready);
    modport sink   (input valid, input lookup_status, input insert_failed, output ready);
endinterface

`default_nettype wire

// ----- src/ip_mac_binding_table.sv -----
// IPv4-to-MAC binding table for ARP spoofing checks. One request at a time: an insert
// appends the pair unless the table already holds TABLE_DEPTH entries (then insert_failed
// is set); a lookup walks the table newest entry first and the first matching IP decides
// the status. Every request yields exactly one response. A lookup's length depends on the
// number of stored entries, set by the single read port of the entry memory, which supplies
// one entry per cycle to the comparator. The response sits in an output register, so a new
// request is taken once the previous result has been handed to it. Reset empties the table
// at once.
`default_nettype none

module ip_mac_binding_table #(
    parameter int TABLE_DEPTH = imbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    imbt_req_if.sink    i_req,
    imbt_rsp_if.source  o_rsp
);

    imbt_pkg::t_cmd cmd;
    imbt_pkg::t_sts sts;

    imbt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (i_req.opcode),
        .o_req_ready  (i_req.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    imbt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_key_ip        (i_req.key_ip),
        .i_key_mac       (i_req.key_mac),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_lookup_status (o_rsp.lookup_status),
        .o_insert_failed (o_rsp.insert_failed)
    );

endmodule

`default_nettype wire

// ----- src/imbt_ram.sv -----
`default_nettype none

module imbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/imbt_ctrl.sv -----
`default_nettype none

module imbt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           i_req_opcode,
    output logic                o_req_ready,
    input  wire imbt_pkg::t_sts i_sts,
    output imbt_pkg::t_cmd      o_cmd
);

    imbt_pkg::t_state r_state;
    imbt_pkg::t_state n_state;
    logic             accept;
    logic             is_lookup;
    logic             go_scan;

    assign accept    = i_req_valid && (r_state == imbt_pkg::S_IDLE);
    assign is_lookup = (i_req_opcode == imbt_pkg::OP_LOOKUP);
    // an empty table answers a lookup at once
    assign go_scan   = is_lookup && !i_sts.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imbt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            imbt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = go_scan ? imbt_pkg::S_SCAN : imbt_pkg::S_DONE;
                end
            end
            imbt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = imbt_pkg::S_DONE;
                end
            end
            imbt_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = imbt_pkg::S_IDLE;
                end
            end
            default: n_state = imbt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            imbt_pkg::S_IDLE: begin
                o_req_ready      = 1'b1;
                o_cmd.latch      = accept;
                o_cmd.write      = accept && !is_lookup && !i_sts.full;
                o_cmd.scan_start = accept && go_scan;
                o_cmd.preset     = accept && !go_scan;
                o_cmd.fail       = !is_lookup && i_sts.full;
            end
            imbt_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            imbt_pkg::S_DONE: begin
                o_cmd.publish = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imbt_pkg::S_SCAN) && i_sts.scan_done |=> (r_state == imbt_pkg::S_DONE))
        else $error("scan finished but result not taken to done");

endmodule

`default_nettype wire

// ----- src/imbt_dp.sv -----
`default_nettype none

module imbt_dp #(
    parameter int TABLE_DEPTH = imbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire imbt_pkg::t_cmd                i_cmd,
    output imbt_pkg::t_sts                     o_sts,
    input  wire logic [imbt_pkg::IP_W-1:0]     i_key_ip,
    input  wire logic [imbt_pkg::MAC_W-1:0]    i_key_mac,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [imbt_pkg::STATUS_W-1:0]      o_lookup_status,
    output logic                               o_insert_failed
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = imbt_pkg::IP_W + imbt_pkg::MAC_W;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              r_idx;
    logic                       r_more;
    logic                       r_rd_pend;
    logic                       r_last;
    logic [imbt_pkg::IP_W-1:0]  r_key_ip;
    logic [imbt_pkg::MAC_W-1:0] r_key_mac;
    imbt_pkg::t_status          r_res_status;
    logic                       r_res_failed;
    logic                       r_out_valid;
    imbt_pkg::t_status          r_out_status;
    logic                       r_out_failed;
    logic [EW-1:0]              rd_data;
    logic                       hit;
    logic                       scan_done;
    logic                       out_free;
    logic                       full;

    imbt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({i_key_ip, i_key_mac}),
        .i_rd_en   (i_cmd.scan_step && r_more),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign count_m1  = r_count - CW'(1);
    assign full      = (r_count == CW'(TABLE_DEPTH));
    // read data belongs to the address issued in the previous cycle
    assign hit       = r_rd_pend && (rd_data[EW-1:imbt_pkg::MAC_W] == r_key_ip);
    assign scan_done = r_rd_pend && (hit || r_last);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.full      = full;
        o_sts.empty     = (r_count == '0);
        o_sts.scan_done = scan_done;
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write) begin
            r_count <= r_count + CW'(1);
        end
    end

    // newest entry first, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_more    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_more    <= 1'b1;
            r_rd_pend <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_pend <= r_more;
            r_more    <= r_more && (r_idx != '0);
        end else begin
            r_more    <= 1'b0;
            r_rd_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= count_m1[AW-1:0];
        end else if (i_cmd.scan_step && r_more) begin
            r_idx  <= r_idx - AW'(1);
            r_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key_ip  <= i_key_ip;
            r_key_mac <= i_key_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.preset) begin
            r_res_status <= imbt_pkg::ST_ABSENT;
            r_res_failed <= i_cmd.fail;
        end else if (i_cmd.scan_step && scan_done) begin
            r_res_failed <= 1'b0;
            if (!hit) begin
                r_res_status <= imbt_pkg::ST_ABSENT;
            end else if (rd_data[imbt_pkg::MAC_W-1:0] == r_key_mac) begin
                r_res_status <= imbt_pkg::ST_MAC_MATCH;
            end else begin
                r_res_status <= imbt_pkg::ST_MAC_DIFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_status <= r_res_status;
            r_out_failed <= r_res_failed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lookup_status = r_out_status;
    assign o_insert_failed = r_out_failed;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> !full)
        else $error("write into a full table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> out_free)
        else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// ----- test/imbt_binding_checker.sv -----
`default_nettype none

module imbt_binding_checker #(
    parameter int DEPTH = imbt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    imbt_req_if       i_req,
    imbt_rsp_if       i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    import imbt_pkg::*;

    typedef struct packed {
        t_status status;
        logic    failed;
    } t_binding_result;

    logic [IP_W-1:0]  bound_ip  [DEPTH];
    logic [MAC_W-1:0] bound_mac [DEPTH];
    int               bound_count = 0;
    t_binding_result  result_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // updates the shadow table and returns the status the block owes for this request
    function automatic t_binding_result apply_binding(t_opcode op, logic [IP_W-1:0] ip,
                                                      logic [MAC_W-1:0] mac);
        t_binding_result res;
        logic            found;
        res.status = ST_ABSENT;
        res.failed = 1'b0;
        found      = 1'b0;
        if (op == OP_INSERT) begin
            if (bound_count >= DEPTH) begin
                res.failed = 1'b1;
            end else begin
                bound_ip[bound_count]  = ip;
                bound_mac[bound_count] = mac;
                bound_count++;
            end
        end else begin
            // newest first, first ip hit decides
            for (int k = bound_count - 1; k >= 0; k--) begin
                if (!found && bound_ip[k] == ip) begin
                    found      = 1'b1;
                    res.status = (bound_mac[k] == mac) ? ST_MAC_MATCH : ST_MAC_DIFF;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        o_fail_count++;
        if (o_fail_count <= 100) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_binding_result want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected response, status %0d failed %0b",
                                              i_rsp.lookup_status, i_rsp.insert_failed));
                end else begin
                    want = result_q.pop_front();
                    if (i_rsp.lookup_status !== want.status) begin
                        report_mismatch($sformatf("lookup_status %0d, predicted %0d",
                                                  i_rsp.lookup_status, want.status));
                    end
                    if (i_rsp.insert_failed !== want.failed) begin
                        report_mismatch($sformatf("insert_failed %0b, predicted %0b",
                                                  i_rsp.insert_failed, want.failed));
                    end
                end
            end
            // response side first: a response can never belong to a request taken this edge
            if (i_req.valid && i_req.ready) begin
                result_q.push_back(apply_binding(t_opcode'(i_req.opcode), i_req.key_ip,
                                                 i_req.key_mac));
            end
        end
        o_pending = result_q.size();
    end

endmodule

`default_nettype wire

// ----- test/tb_ip_mac_binding_table.sv -----
`default_nettype none

module tb_ip_mac_binding_table;

    import imbt_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    logic i_clk   = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet   = 1'b0;

    // the first DEPTH inserted pairs, used to steer lookups towards hits and inserts to duplicate ips
    logic [IP_W-1:0]  sent_ip  [$];
    logic [MAC_W-1:0] sent_mac [$];
    int               inserts_sent = 0;

    imbt_req_if req_bus ();
    imbt_rsp_if rsp_bus ();

    ip_mac_binding_table #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    imbt_binding_checker #(
        .DEPTH (DEPTH)
    ) i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // mostly back to back, some short pauses, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [31:0] hi;
        hi = $urandom;
        return {hi[15:0], 32'($urandom)};
    endfunction

    task automatic send_request(t_opcode op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        int gap;
        req_bus.valid   <= 1'b1;
        req_bus.opcode  <= op;
        req_bus.key_ip  <= ip;
        req_bus.key_mac <= mac;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        if (op == OP_INSERT) begin
            inserts_sent++;
            if (sent_ip.size() < DEPTH) begin
                sent_ip.push_back(ip);
                sent_mac.push_back(mac);
            end
        end
        if (!quiet) begin
            gap = gap_len();
            if (gap > 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_random_lookup();
        int               r;
        int               idx;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        r   = $urandom_range(0, 99);
        ip  = $urandom;
        mac = rand_mac();
        if (sent_ip.size() > 0 && r < 80) begin
            idx = $urandom_range(0, sent_ip.size() - 1);
            ip  = sent_ip[idx];
            if (r < 30) begin
                mac = sent_mac[idx];
            end else if (r < 50) begin
                mac = sent_mac[idx] ^ (48'h1 << $urandom_range(0, MAC_W - 1));
            end else if (r >= 65) begin
                // near miss on the ip
                ip = ip ^ (32'h1 << $urandom_range(0, IP_W - 1));
            end
        end
        send_request(OP_LOOKUP, ip, mac);
    endtask

    task automatic send_random_insert();
        logic [IP_W-1:0] ip;
        ip = $urandom;
        // some duplicate ips so the newest binding has to win
        if (sent_ip.size() > 0 && $urandom_range(0, 3) == 0) begin
            ip = sent_ip[$urandom_range(0, sent_ip.size() - 1)];
        end
        send_request(OP_INSERT, ip, rand_mac());
    endtask

    // response side back-pressure
    initial begin
        int gap;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet) begin
                gap = gap_len();
                if (gap > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_bus.valid   <= 1'b0;
        req_bus.opcode  <= OP_INSERT;
        req_bus.key_ip  <= '0;
        req_bus.key_mac <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, field extremes, mac mismatch, duplicate ip
        send_request(OP_LOOKUP, 32'h0, 48'h0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(OP_INSERT, 32'h0, 48'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(OP_LOOKUP, 32'h0, 48'h0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_request(OP_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_request(OP_LOOKUP, 32'h0000_0001, 48'h0);
        send_request(OP_LOOKUP, 32'h8000_0000, 48'h8000_0000_0000);
        send_request(OP_INSERT, 32'h0, 48'h0123_4567_89AB);
        send_request(OP_LOOKUP, 32'h0, 48'h0123_4567_89AB);
        send_request(OP_LOOKUP, 32'h0, 48'h0);
        send_request(OP_INSERT, 32'hC0A8_0001, 48'hA5A5_5A5A_A5A5);
        send_request(OP_LOOKUP, 32'hC0A8_0001, 48'hA5A5_5A5A_A5A5);
        send_request(OP_LOOKUP, 32'hC0A8_0001, 48'h5A5A_A5A5_5A5A);
        send_request(OP_LOOKUP, 32'hC0A8_0002, 48'hA5A5_5A5A_A5A5);

        // random: fill the table over the first few hundred items, then keep hitting it full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < ((inserts_sent < DEPTH) ? 14 : 6)) begin
                send_random_insert();
            end else begin
                send_random_lookup();
            end
        end
        // a few extra inserts on a table that must already be full
        repeat (4) send_random_insert();
        send_random_lookup();

        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
